### src/hfn_pkg.sv
// Package for the height-field normal stream: field widths, reset values,
// configuration register codes and the command and status types.
// No dependencies.
`timescale 1ns / 1ps

package hfn_pkg;

  localparam int HFN_MAX_COLS = 32;
  localparam int HFN_MAX_ROWS = 1024;

  localparam int HGT_W      = 16;
  localparam int NRM_W      = 37;
  localparam int COLIDX_W   = 5;
  localparam int ROWIDX_W   = 10;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int COLS_W     = 6;
  localparam int SPACING_W  = 16;

  localparam logic [COLS_W-1:0]    COLS_RST    = 6'd32;
  localparam logic [SPACING_W-1:0] SPACING_RST = 16'd3277;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 4'd1;

  typedef logic [1:0] hfn_slot_t;

  typedef struct packed {
    logic      wr;
    hfn_slot_t wr_slot;
    logic      rd_b;
    logic      diff;
    logic      mul;
    logic      load;
    hfn_slot_t sm;
    hfn_slot_t sp;
    logic [1:0] b;
    logic      last;
  } hfn_cmd_t;

  typedef struct packed {
    logic out_free;
  } hfn_stat_t;

endpackage

### src/hfn_if.sv
// Channel interfaces of the height-field normal stream: height input,
// normal output and configuration write. Depends on hfn_pkg.
`timescale 1ns / 1ps

interface hfn_in_if import hfn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HGT_W-1:0] height;
  logic                    last_sample;

  modport source (output valid, height, last_sample, input ready);
  modport sink (input valid, height, last_sample, output ready);
endinterface

interface hfn_out_if import hfn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [COLIDX_W-1:0]     column_index;
  logic [ROWIDX_W-1:0]     row_index;
  logic                    last_normal;

  modport source (output valid, normal_x, normal_y, normal_z, column_index, row_index,
                  last_normal, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, column_index, row_index,
                last_normal, output ready);
endinterface

interface hfn_cfg_if import hfn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/hfn_ctrl.sv
// Controller of the height-field normal stream: row and column tracking,
// per-sample job list and the per-normal sequence. Depends on hfn_pkg, hfn_if.
`timescale 1ns / 1ps

module hfn_ctrl import hfn_pkg::*; #(
  parameter int MAX_COLS = HFN_MAX_COLS,
  parameter int MAX_ROWS = HFN_MAX_ROWS,
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hfn_in_if.sink           in_i,
  input  logic [ColW-1:0]  wm1_i,
  input  hfn_stat_t        stat_i,
  output hfn_cmd_t         cmd_o,
  output logic [ColW-1:0]  wr_col_o,
  output logic [ColW-1:0]  job_col_o,
  output logic [ColW-1:0]  job_wm1_o,
  output logic [RowW-1:0]  job_row_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_RDA  = 3'd2;
  localparam logic [2:0] ST_RDB  = 3'd3;
  localparam logic [2:0] ST_DIF  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [RowW-1:0] RowMax = RowW'(MAX_ROWS - 1);

  logic [2:0]      state_q, state_d;
  logic [ColW-1:0] cc_q, cc_d;
  logic [RowW-1:0] row_q, row_d;
  hfn_slot_t       cur_q, cur_d;
  logic [1:0]      held_q, held_d;
  logic            over_q, over_d;

  logic [ColW-1:0] c_q, wm1_q, fj_q;
  hfn_slot_t       slot_q, old_q, fsm_q;
  logic [1:0]      bn_q, bf_q;
  logic [RowW-1:0] lag_q, rowf_q;
  logic            pv_q, en_q, fl_q;

  logic [ColW-1:0] jcol_q;
  hfn_slot_t       jsm_q;
  logic [1:0]      jb_q;
  logic [RowW-1:0] jrow_q;
  logic            jlast_q;

  logic            accept;
  logic [ColW-1:0] c_w;
  logic            is_end, last_w, one_w, two_w;
  hfn_slot_t       up_w, nxt_w;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign c_w    = (cc_q > wm1_i) ? wm1_i : cc_q;
  assign is_end = (c_w == wm1_i);
  assign last_w = in_i.last_sample && is_end;
  assign one_w  = (held_q != 2'd0);
  assign two_w  = (held_q >= 2'd2);
  assign up_w   = (cur_q == 2'd0) ? 2'd2 : cur_q - 2'd1;
  assign nxt_w  = (cur_q == 2'd2) ? 2'd0 : cur_q + 2'd1;

  always_comb begin
    cc_d   = cc_q;
    row_d  = row_q;
    cur_d  = cur_q;
    held_d = held_q;
    over_d = over_q;
    if (accept) begin
      if (last_w) begin
        cc_d   = '0;
        row_d  = '0;
        cur_d  = 2'd0;
        held_d = 2'd0;
        over_d = 1'b0;
      end else if (is_end) begin
        cc_d = '0;
        if (row_q != RowMax) begin
          row_d = row_q + 1'b1;
        end else begin
          over_d = 1'b1;
        end
        cur_d = nxt_w;
        if (!two_w) begin
          held_d = held_q + 2'd1;
        end
      end else begin
        cc_d = c_w + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_DISP;
      ST_DISP: state_d = (pv_q || en_q || fl_q) ? ST_RDA : ST_IDLE;
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_DIF;
      ST_DIF:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (stat_i.out_free) state_d = ST_DISP;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cc_q    <= '0;
      row_q   <= '0;
      cur_q   <= 2'd0;
      held_q  <= 2'd0;
      over_q  <= 1'b0;
      pv_q    <= 1'b0;
      en_q    <= 1'b0;
      fl_q    <= 1'b0;
      fj_q    <= '0;
    end else begin
      state_q <= state_d;
      cc_q    <= cc_d;
      row_q   <= row_d;
      cur_q   <= cur_d;
      held_q  <= held_d;
      over_q  <= over_d;
      if (accept) begin
        pv_q <= one_w && (c_w != '0);
        en_q <= one_w && is_end;
        fl_q <= last_w;
        fj_q <= '0;
      end else if (state_q == ST_DISP) begin
        if (pv_q) begin
          pv_q <= 1'b0;
        end else if (en_q) begin
          en_q <= 1'b0;
        end else if (fl_q) begin
          if (fj_q == wm1_q) begin
            fl_q <= 1'b0;
          end else begin
            fj_q <= fj_q + 1'b1;
          end
        end
      end
    end
  end

  // Snapshot of the sample's context, taken at the input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q    <= c_w;
      wm1_q  <= wm1_i;
      slot_q <= cur_q;
      old_q  <= two_w ? nxt_w : up_w;
      bn_q   <= two_w ? 2'd2 : 2'd1;
      lag_q  <= over_q ? RowMax : row_q - 1'b1;
      fsm_q  <= one_w ? up_w : cur_q;
      bf_q   <= one_w ? 2'd1 : 2'd0;
      rowf_q <= row_q;
    end
    if (state_q == ST_DISP) begin
      if (pv_q) begin
        jcol_q  <= c_q - 1'b1;
        jsm_q   <= old_q;
        jb_q    <= bn_q;
        jrow_q  <= lag_q;
        jlast_q <= 1'b0;
      end else if (en_q) begin
        jcol_q  <= wm1_q;
        jsm_q   <= old_q;
        jb_q    <= bn_q;
        jrow_q  <= lag_q;
        jlast_q <= 1'b0;
      end else begin
        jcol_q  <= fj_q;
        jsm_q   <= fsm_q;
        jb_q    <= bf_q;
        jrow_q  <= rowf_q;
        jlast_q <= (fj_q == wm1_q);
      end
    end
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.wr      = accept;
    cmd_o.wr_slot = cur_q;
    cmd_o.rd_b    = (state_q == ST_RDB);
    cmd_o.diff    = (state_q == ST_DIF);
    cmd_o.mul     = (state_q == ST_MUL);
    cmd_o.load    = (state_q == ST_OUT) && stat_i.out_free;
    cmd_o.sm      = jsm_q;
    cmd_o.sp      = slot_q;
    cmd_o.b       = jb_q;
    cmd_o.last    = jlast_q;
  end

  assign wr_col_o  = c_w;
  assign job_col_o = jcol_q;
  assign job_wm1_o = wm1_q;
  assign job_row_o = jrow_q;

endmodule

### src/hfn_datapath.sv
// Datapath of the height-field normal stream: three-row line store, height
// differences, products and the output register. Depends on hfn_pkg, hfn_if.
`timescale 1ns / 1ps

module hfn_datapath import hfn_pkg::*; #(
  parameter int MAX_COLS = HFN_MAX_COLS,
  parameter int MAX_ROWS = HFN_MAX_ROWS,
  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hfn_cmd_t                cmd_i,
  output hfn_stat_t               stat_o,
  input  logic signed [HGT_W-1:0] height_i,
  input  logic [ColW-1:0]         wr_col_i,
  input  logic [ColW-1:0]         job_col_i,
  input  logic [ColW-1:0]         job_wm1_i,
  input  logic [RowW-1:0]         job_row_i,
  input  logic [SPACING_W-1:0]    spacing_i,
  hfn_out_if.source               out_o
);

  localparam int Depth = 3 * MAX_COLS;
  localparam int AddrW = $clog2(Depth);

  function automatic logic [AddrW-1:0] addr_of(hfn_slot_t slot, logic [ColW-1:0] col);
    logic [AddrW-1:0] base;
    unique case (slot)
      2'd0:    base = '0;
      2'd1:    base = AddrW'(MAX_COLS);
      default: base = AddrW'(2 * MAX_COLS);
    endcase
    return base + AddrW'(col);
  endfunction

  logic signed [HGT_W-1:0] mem_q [Depth];
  logic signed [HGT_W-1:0] rd0_q, rd1_q, hold_p_q, hold_m_q;
  logic [ColW-1:0]         xm, xp;
  logic [1:0]              a;
  logic [AddrW-1:0]        ra0, ra1;

  logic signed [16:0] dz1, dz2, spacing_s;
  logic signed [17:0] diff_q, sum_q;
  logic signed [34:0] px_q, py_q;
  logic [31:0]        ss_q;
  logic [3:0]         ab;

  logic signed [NRM_W-1:0] nx, ay, ny;
  logic [NRM_W-1:0]        zt, zr, nz;
  logic                    valid_q;

  assign xm = (job_col_i == '0) ? '0 : job_col_i - 1'b1;
  assign xp = (job_col_i >= job_wm1_i) ? job_wm1_i : job_col_i + 1'b1;
  assign a  = 2'(xp - xm);

  assign ra0 = cmd_i.rd_b ? addr_of(cmd_i.sp, xm) : addr_of(cmd_i.sp, xp);
  assign ra1 = cmd_i.rd_b ? addr_of(cmd_i.sm, xp) : addr_of(cmd_i.sm, xm);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_of(cmd_i.wr_slot, wr_col_i)] <= height_i;
    end
    rd0_q <= mem_q[ra0];
    rd1_q <= mem_q[ra1];
  end

  assign dz1       = $signed({hold_p_q[HGT_W-1], hold_p_q})
                   - $signed({hold_m_q[HGT_W-1], hold_m_q});
  assign dz2       = $signed({rd0_q[HGT_W-1], rd0_q}) - $signed({rd1_q[HGT_W-1], rd1_q});
  assign spacing_s = $signed({1'b0, spacing_i});

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_b) begin
      hold_p_q <= rd0_q;
      hold_m_q <= rd1_q;
    end
    if (cmd_i.diff) begin
      diff_q <= $signed({dz2[16], dz2}) - $signed({dz1[16], dz1});
      sum_q  <= $signed({dz1[16], dz1}) + $signed({dz2[16], dz2});
    end
    if (cmd_i.mul) begin
      px_q <= 35'(diff_q) * 35'(spacing_s);
      py_q <= 35'(sum_q) * 35'(spacing_s);
      ss_q <= 32'(spacing_i) * 32'(spacing_i);
    end
  end

  assign ab = {2'b00, a} * {2'b00, cmd_i.b};

  always_comb begin
    case (cmd_i.b)
      2'd1:    nx = {{2{px_q[34]}}, px_q};
      2'd2:    nx = {px_q[34], px_q, 1'b0};
      default: nx = '0;
    endcase
    case (a)
      2'd1:    ay = {{2{py_q[34]}}, py_q};
      2'd2:    ay = {py_q[34], py_q, 1'b0};
      default: ay = '0;
    endcase
    case (ab)
      4'd1:    zt = {4'b0, ss_q, 1'b0};
      4'd2:    zt = {3'b0, ss_q, 2'b0};
      4'd4:    zt = {2'b0, ss_q, 3'b0};
      default: zt = '0;
    endcase
  end

  assign ny = -ay;
  assign zr = zt + 37'd8;
  assign nz = {4'b0, zr[NRM_W-1:4]};

  assign stat_o.out_free = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_o.normal_x     <= nx;
      out_o.normal_y     <= ny;
      out_o.normal_z     <= $signed(nz);
      out_o.column_index <= COLIDX_W'(job_col_i);
      out_o.row_index    <= ROWIDX_W'(job_row_i);
      out_o.last_normal  <= cmd_i.last;
    end
  end

  assign out_o.valid = valid_q;

endmodule

### src/heightfield_normal_stream.sv
// Top level of the height-field normal stream: configuration registers,
// controller and datapath. Depends on hfn_pkg, hfn_if, hfn_ctrl, hfn_datapath.
//
//   channel  modport  payload
//   in_i     sink     height, last_sample
//   out_o    source   normal_x, normal_y, normal_z, column_index, row_index, last_normal
//   cfg_i    sink     index (0 columns, 1 grid_spacing), data
//
// One sample at a time: a sample producing n normals (0 to MAX_COLS + 2)
// is worked through the two-port line store read and one shared multiply
// path per normal. An output stall holds the sequence in the output state.
// Reset clears all control; the line store holds no reset value.
`timescale 1ns / 1ps

module heightfield_normal_stream import hfn_pkg::*; #(
  parameter int MAX_COLS = HFN_MAX_COLS,
  parameter int MAX_ROWS = HFN_MAX_ROWS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hfn_in_if.sink    in_i,
  hfn_out_if.source out_o,
  hfn_cfg_if.sink   cfg_i
);

  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [COLS_W-1:0]    columns_q;
  logic [SPACING_W-1:0] spacing_q;
  logic [ColW-1:0]      wm1;
  logic [ColW-1:0]      wr_col, job_col, job_wm1;
  logic [RowW-1:0]      job_row;
  hfn_cmd_t             cmd;
  hfn_stat_t            stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLS_RST;
      spacing_q <= SPACING_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COLUMNS: columns_q <= cfg_i.data[COLS_W-1:0];
        CFG_SPACING: spacing_q <= cfg_i.data[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the row width to 1..MAX_COLS
  always_comb begin
    if (columns_q == '0) begin
      wm1 = '0;
    end else if (columns_q > COLS_W'(MAX_COLS)) begin
      wm1 = ColW'(MAX_COLS - 1);
    end else begin
      wm1 = ColW'(columns_q - 1'b1);
    end
  end

  hfn_ctrl #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .wm1_i     (wm1),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .wr_col_o  (wr_col),
    .job_col_o (job_col),
    .job_wm1_o (job_wm1),
    .job_row_o (job_row)
  );

  hfn_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .height_i  (in_i.height),
    .wr_col_i  (wr_col),
    .job_col_i (job_col),
    .job_wm1_i (job_wm1),
    .job_row_i (job_row),
    .spacing_i (spacing_q),
    .out_o     (out_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken while a sample is in work");

  a_last_in_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_normal) |-> (out_o.column_index == COLIDX_W'(wm1)))
    else $error("frame end normal outside the last column");

  a_single_col_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && wm1 == '0) |-> (out_o.normal_y == '0 && out_o.normal_z == '0))
    else $error("single column grid gave a sloped normal");

  a_z_not_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.normal_z[NRM_W-1])
    else $error("negative z component");

endmodule
